FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define VIA_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("via assertion failed");

// Checked on every clock edge, reset included.
`define VIA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("via assertion failed");

`endif

FILE: rtl/core/via_pkg.sv
package via_pkg;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_SAMPLE = 2'd3;

  localparam logic [3:0] REG_ORB    = 4'h0;
  localparam logic [3:0] REG_ORA    = 4'h1;
  localparam logic [3:0] REG_DDRB   = 4'h2;
  localparam logic [3:0] REG_DDRA   = 4'h3;
  localparam logic [3:0] REG_T1CL   = 4'h4;
  localparam logic [3:0] REG_T1CH   = 4'h5;
  localparam logic [3:0] REG_T1LL   = 4'h6;
  localparam logic [3:0] REG_T1LH   = 4'h7;
  localparam logic [3:0] REG_T2CL   = 4'h8;
  localparam logic [3:0] REG_T2CH   = 4'h9;
  localparam logic [3:0] REG_SR     = 4'hA;
  localparam logic [3:0] REG_ACR    = 4'hB;
  localparam logic [3:0] REG_PCR    = 4'hC;
  localparam logic [3:0] REG_IFR    = 4'hD;
  localparam logic [3:0] REG_IER    = 4'hE;
  localparam logic [3:0] REG_ORA_NH = 4'hF;

  // Flag and enable bit positions.
  localparam int unsigned FLAG_CA2 = 0;
  localparam int unsigned FLAG_CA1 = 1;
  localparam int unsigned FLAG_SR  = 2;
  localparam int unsigned FLAG_CB2 = 3;
  localparam int unsigned FLAG_CB1 = 4;
  localparam int unsigned FLAG_T2  = 5;
  localparam int unsigned FLAG_T1  = 6;

  // Control line modes (PCR CA2/CB2 field).
  localparam logic [2:0] MODE_IND_NEG   = 3'd1;
  localparam logic [2:0] MODE_IND_POS   = 3'd3;
  localparam logic [2:0] MODE_HANDSHAKE = 3'd4;
  localparam logic [2:0] MODE_PULSE     = 3'd5;
  localparam logic [2:0] MODE_MANUAL    = 3'd6;

  localparam logic [15:0] TIMER_ONES = 16'hFFFF;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] port_a_in;
    logic [7:0] port_b_in;
    logic       ca1_level;
    logic       cb1_level;
    logic       ca2_level;
    logic       cb2_level;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       ca2_out;
    logic       cb2_out;
    logic       irq_active;
  } rsp_t;

  function automatic logic [7:0] pins_a(input logic [7:0] ora, input logic [7:0] ddr,
                                        input logic [7:0] pin);
    return (ora & ddr) | (pin & ~ddr);
  endfunction

  function automatic logic [7:0] pins_b(input logic [7:0] orb, input logic [7:0] ddr,
                                        input logic [7:0] pin, input logic [7:0] acr,
                                        input logic toggle);
    logic [7:0] v;
    v = (orb & ddr) | (pin & ~ddr);
    if (acr[7] && ddr[7]) v[7] = toggle;
    return v;
  endfunction

  // Input modes 1 and 3 keep the CA2/CB2 flag on a port access.
  function automatic logic independent(input logic [2:0] mode);
    return (mode == MODE_IND_NEG) || (mode == MODE_IND_POS);
  endfunction

endpackage

FILE: rtl/core/via_req_if.sv
interface via_req_if;
  logic          valid;
  logic          ready;
  via_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/via_rsp_if.sv
interface via_rsp_if;
  logic          valid;
  logic          ready;
  via_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/versatile_interface_adapter.sv
// Pipeline: a beat accepted on req passes through the input register, then the
// result register, before its result shows on rsp.
// Throughput: one beat per cycle while rsp is ready; register file update and result load happen in the same cycle.
// Reset: synchronous, active high; empties both pipeline registers and loads
// the register file reset values at once, with no clearing pass.
`include "assert_macros.svh"

module versatile_interface_adapter (
  input logic       clk,
  input logic       rst,
  via_req_if.sink   req,
  via_rsp_if.source rsp
);
  import via_pkg::*;

  logic  in_valid;
  req_t  in_item;
  logic  out_valid;
  rsp_t  out_item;
  logic  advance;
  rsp_t  result;

  // Process the held beat when the result register is free or draining.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  via_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) in_item <= req.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= result;
  end

  `VIA_ASSERT_ALWAYS(a_reset_empty, rst |=> !in_valid && !out_valid)
  `VIA_ASSERT(a_advance_fills, advance |=> out_valid)
  `VIA_ASSERT(a_held_beat_stable, in_valid && !advance |=> in_valid && $stable(in_item))
  `VIA_ASSERT(a_read_data_zero, advance && in_item.command != CMD_READ |=> out_item.read_data == 8'h00)

endmodule

FILE: rtl/core/via_regs.sv
module via_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  via_pkg::req_t item,
  output via_pkg::rsp_t result
);
  import via_pkg::*;

  logic [7:0]  port_b_output, port_b_output_next;
  logic [7:0]  port_a_output, port_a_output_next;
  logic [7:0]  port_b_direction, port_b_direction_next;
  logic [7:0]  port_a_direction, port_a_direction_next;
  logic [15:0] timer1_count, timer1_count_next;
  logic [15:0] timer1_latch, timer1_latch_next;
  logic [15:0] timer2_count, timer2_count_next;
  logic [7:0]  timer2_latch_low, timer2_latch_low_next;
  logic [7:0]  shift_value, shift_value_next;
  logic [7:0]  aux_control, aux_control_next;
  logic [7:0]  periph_control, periph_control_next;
  logic [6:0]  flag_bits, flag_bits_next;
  logic [6:0]  enable_bits, enable_bits_next;
  logic        timer1_running, timer1_running_next;
  logic        timer2_running, timer2_running_next;
  logic        pb7_toggle, pb7_toggle_next;
  logic        ca2_drive, ca2_drive_next;
  logic        cb2_drive, cb2_drive_next;
  logic [3:0]  previous_lines, previous_lines_next;

  logic [2:0]  mode_a, mode_b;
  logic [7:0]  rd;
  logic        ca1_edge, cb1_edge, ca2_edge, cb2_edge;

  assign mode_a = periph_control[3:1];
  assign mode_b = periph_control[7:5];

  always_comb begin
    ca1_edge = periph_control[0] ? (item.ca1_level && !previous_lines[0])
                                 : (!item.ca1_level && previous_lines[0]);
    cb1_edge = periph_control[4] ? (item.cb1_level && !previous_lines[1])
                                 : (!item.cb1_level && previous_lines[1]);
    ca2_edge = (mode_a[2] || mode_a[1]) ? (item.ca2_level && !previous_lines[2])
                                        : (!item.ca2_level && previous_lines[2]);
    cb2_edge = (mode_b[2] || mode_b[1]) ? (item.cb2_level && !previous_lines[3])
                                        : (!item.cb2_level && previous_lines[3]);
  end

  always_comb begin
    port_b_output_next    = port_b_output;
    port_a_output_next    = port_a_output;
    port_b_direction_next = port_b_direction;
    port_a_direction_next = port_a_direction;
    timer1_count_next     = timer1_count;
    timer1_latch_next     = timer1_latch;
    timer2_count_next     = timer2_count;
    timer2_latch_low_next = timer2_latch_low;
    shift_value_next      = shift_value;
    aux_control_next      = aux_control;
    periph_control_next   = periph_control;
    flag_bits_next        = flag_bits;
    enable_bits_next      = enable_bits;
    timer1_running_next   = timer1_running;
    timer2_running_next   = timer2_running;
    pb7_toggle_next       = pb7_toggle;
    ca2_drive_next        = ca2_drive;
    cb2_drive_next        = cb2_drive;
    previous_lines_next   = previous_lines;
    rd                    = 8'h00;

    unique case (item.command)
      CMD_READ: begin
        unique case (item.reg_index)
          REG_ORB: begin
            rd = pins_b(port_b_output, port_b_direction, item.port_b_in,
                        aux_control, pb7_toggle);
            flag_bits_next[FLAG_CB1] = 1'b0;
            if (!independent(mode_b)) flag_bits_next[FLAG_CB2] = 1'b0;
          end
          REG_ORA: begin
            rd = pins_a(port_a_output, port_a_direction, item.port_a_in);
            flag_bits_next[FLAG_CA1] = 1'b0;
            if (!independent(mode_a)) flag_bits_next[FLAG_CA2] = 1'b0;
            if (mode_a == MODE_HANDSHAKE || mode_a == MODE_PULSE) ca2_drive_next = 1'b0;
          end
          REG_DDRB: rd = port_b_direction;
          REG_DDRA: rd = port_a_direction;
          REG_T1CL: begin
            rd = timer1_count[7:0];
            flag_bits_next[FLAG_T1] = 1'b0;
          end
          REG_T1CH: rd = timer1_count[15:8];
          REG_T1LL: rd = timer1_latch[7:0];
          REG_T1LH: rd = timer1_latch[15:8];
          REG_T2CL: begin
            rd = timer2_count[7:0];
            flag_bits_next[FLAG_T2] = 1'b0;
          end
          REG_T2CH: rd = timer2_count[15:8];
          REG_SR: begin
            rd = shift_value;
            flag_bits_next[FLAG_SR] = 1'b0;
          end
          REG_ACR: rd = aux_control;
          REG_PCR: rd = periph_control;
          REG_IFR: rd = {|(flag_bits & enable_bits), flag_bits};
          REG_IER: rd = {1'b1, enable_bits};
          REG_ORA_NH: rd = pins_a(port_a_output, port_a_direction, item.port_a_in);
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_index)
          REG_ORB: begin
            port_b_output_next = item.write_data;
            flag_bits_next[FLAG_CB1] = 1'b0;
            if (!independent(mode_b)) flag_bits_next[FLAG_CB2] = 1'b0;
            if (mode_b == MODE_HANDSHAKE || mode_b == MODE_PULSE) cb2_drive_next = 1'b0;
          end
          REG_ORA: begin
            port_a_output_next = item.write_data;
            flag_bits_next[FLAG_CA1] = 1'b0;
            if (!independent(mode_a)) flag_bits_next[FLAG_CA2] = 1'b0;
            if (mode_a == MODE_HANDSHAKE || mode_a == MODE_PULSE) ca2_drive_next = 1'b0;
          end
          REG_DDRB: port_b_direction_next = item.write_data;
          REG_DDRA: port_a_direction_next = item.write_data;
          REG_T1CL, REG_T1LL: timer1_latch_next = {timer1_latch[15:8], item.write_data};
          REG_T1CH: begin
            timer1_latch_next   = {item.write_data, timer1_latch[7:0]};
            timer1_count_next   = {item.write_data, timer1_latch[7:0]};
            timer1_running_next = 1'b1;
            pb7_toggle_next     = 1'b0;
            flag_bits_next[FLAG_T1] = 1'b0;
          end
          REG_T1LH: begin
            timer1_latch_next = {item.write_data, timer1_latch[7:0]};
            flag_bits_next[FLAG_T1] = 1'b0;
          end
          REG_T2CL: timer2_latch_low_next = item.write_data;
          REG_T2CH: begin
            timer2_count_next   = {item.write_data, timer2_latch_low};
            timer2_running_next = 1'b1;
            flag_bits_next[FLAG_T2] = 1'b0;
          end
          REG_SR: begin
            shift_value_next = item.write_data;
            flag_bits_next[FLAG_SR] = 1'b0;
          end
          REG_ACR: aux_control_next = item.write_data;
          REG_PCR: begin
            periph_control_next = item.write_data;
            if (item.write_data[3:1] >= MODE_MANUAL) ca2_drive_next = item.write_data[3];
            if (item.write_data[7:5] >= MODE_MANUAL) cb2_drive_next = item.write_data[7];
          end
          REG_IFR: flag_bits_next = flag_bits & ~item.write_data[6:0];
          REG_IER: begin
            if (item.write_data[7]) enable_bits_next = enable_bits | item.write_data[6:0];
            else enable_bits_next = enable_bits & ~item.write_data[6:0];
          end
          REG_ORA_NH: port_a_output_next = item.write_data;
        endcase
      end
      CMD_TICK: begin
        // pulse mode releases the line on the next tick
        if (mode_a == MODE_PULSE) ca2_drive_next = 1'b1;
        if (mode_b == MODE_PULSE) cb2_drive_next = 1'b1;
        if (timer1_running) begin
          if (timer1_count == 16'd0) begin
            timer1_count_next = timer1_latch;
            flag_bits_next[FLAG_T1] = 1'b1;
            pb7_toggle_next = !pb7_toggle;
            if (!aux_control[6]) timer1_running_next = 1'b0;
          end else begin
            timer1_count_next = timer1_count - 16'd1;
          end
        end
        if (timer2_running && !aux_control[5]) begin
          if (timer2_count == 16'd0) begin
            timer2_count_next   = TIMER_ONES;
            flag_bits_next[FLAG_T2] = 1'b1;
            timer2_running_next = 1'b0;
          end else begin
            timer2_count_next = timer2_count - 16'd1;
          end
        end
      end
      CMD_SAMPLE: begin
        previous_lines_next = {item.cb2_level, item.ca2_level, item.cb1_level, item.ca1_level};
        if (ca1_edge) begin
          flag_bits_next[FLAG_CA1] = 1'b1;
          if (mode_a == MODE_HANDSHAKE) ca2_drive_next = 1'b1;
        end
        if (cb1_edge) begin
          flag_bits_next[FLAG_CB1] = 1'b1;
          if (mode_b == MODE_HANDSHAKE) cb2_drive_next = 1'b1;
        end
        // output modes only record the level
        if (ca2_edge && !mode_a[2]) flag_bits_next[FLAG_CA2] = 1'b1;
        if (cb2_edge && !mode_b[2]) flag_bits_next[FLAG_CB2] = 1'b1;
      end
    endcase

    result.read_data  = rd;
    result.port_a_out = pins_a(port_a_output_next, port_a_direction_next, item.port_a_in);
    result.port_b_out = pins_b(port_b_output_next, port_b_direction_next, item.port_b_in,
                               aux_control_next, pb7_toggle_next);
    result.ca2_out    = ca2_drive_next;
    result.cb2_out    = cb2_drive_next;
    result.irq_active = |(flag_bits_next & enable_bits_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_b_output    <= 8'h00;
      port_a_output    <= 8'h00;
      port_b_direction <= 8'h00;
      port_a_direction <= 8'h00;
      timer1_count     <= TIMER_ONES;
      timer1_latch     <= TIMER_ONES;
      timer2_count     <= TIMER_ONES;
      timer2_latch_low <= 8'hFF;
      shift_value      <= 8'h00;
      aux_control      <= 8'h00;
      periph_control   <= 8'h00;
      flag_bits        <= 7'h00;
      enable_bits      <= 7'h00;
      timer1_running   <= 1'b0;
      timer2_running   <= 1'b0;
      pb7_toggle       <= 1'b1;
      ca2_drive        <= 1'b0;
      cb2_drive        <= 1'b0;
      previous_lines   <= 4'h0;
    end else if (advance) begin
      port_b_output    <= port_b_output_next;
      port_a_output    <= port_a_output_next;
      port_b_direction <= port_b_direction_next;
      port_a_direction <= port_a_direction_next;
      timer1_count     <= timer1_count_next;
      timer1_latch     <= timer1_latch_next;
      timer2_count     <= timer2_count_next;
      timer2_latch_low <= timer2_latch_low_next;
      shift_value      <= shift_value_next;
      aux_control      <= aux_control_next;
      periph_control   <= periph_control_next;
      flag_bits        <= flag_bits_next;
      enable_bits      <= enable_bits_next;
      timer1_running   <= timer1_running_next;
      timer2_running   <= timer2_running_next;
      pb7_toggle       <= pb7_toggle_next;
      ca2_drive        <= ca2_drive_next;
      cb2_drive        <= cb2_drive_next;
      previous_lines   <= previous_lines_next;
    end
  end

endmodule
